### sv/htw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_pkg
// Shared constants, codes and types of the hierarchical timer wheel.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int TIMERS  = 64;
  localparam int SLOTS   = 64;
  localparam int LEVELS  = 3;

  localparam int ID_W    = $clog2(TIMERS);
  localparam int PTR_W   = ID_W + 1;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int HEADS   = LEVELS * SLOTS;
  localparam int HEAD_W  = LVL_W + SLOT_W;
  localparam int TO_W    = 24;
  localparam int REP_W   = 16;
  localparam int TP_W    = 16;
  localparam int SPAN_W  = TP_W + SLOT_W * LEVELS;
  localparam int RES_MAX = 64;
  localparam int CNT_W   = $clog2(RES_MAX + 1);

  localparam logic [REP_W-1:0] REPEAT_FOREVER = '1;
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(TIMERS);

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  typedef enum logic [1:0] {
    EV_EXPIRED    = 2'd0,
    EV_REMOVED    = 2'd1,
    EV_ADD_FAILED = 2'd2
  } ev_t;

  typedef enum logic [1:0] {
    DS_INSERT,
    DS_MOD,
    DS_CASC
  } div_src_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD, S_TICK, S_DR_RD, S_DR_HEAD, S_ND_RD, S_ND_EVAL, S_CASC,
    S_DIV_M, S_DIV_Q, S_LK_RD, S_LK_WR, S_EXP, S_REP, S_RM, S_FAIL, S_NEXT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       add_do;
    logic       tick_do;
    logic       dr_rd;
    logic       dr_take;
    logic       dl_dec;
    logic       nd_rd;
    logic       nd_take;
    logic       div_start;
    div_src_t   div_src;
    logic       lk_rd;
    logic       lk_wr;
    logic       rep_wr;
    logic       emit;
    ev_t        emit_code;
    logic       flush;
    logic       nxt_adv;
  } cmd_t;

  typedef struct packed {
    logic linked_cur;
    logic active_cur;
    logic fit_ok;
    logic head_null;
    logic nxt_null;
    logic dl_zero;
    logic again;
    logic div_busy;
    logic div_valid;
    logic emit_ok;
    logic flush_ok;
    logic is_tick;
  } sts_t;

  typedef struct packed {
    logic             ok;
    logic [LVL_W-1:0] lvl;
  } fit_t;

  // lowest level whose span (tick * SLOTS) exceeds the timeout
  function automatic fit_t level_fit(input logic [TO_W-1:0] t, input logic [TP_W-1:0] tp);
    fit_t              f;
    logic [SPAN_W-1:0] span;
    f = '0;
    for (int k = 0; k < LEVELS; k++) begin
      span = SPAN_W'(tp) << (SLOT_W * (k + 1));
      if (!f.ok && (SPAN_W'(t) < span)) begin
        f.ok  = 1'b1;
        f.lvl = LVL_W'(k);
      end
    end
    return f;
  endfunction

endpackage

### sv/htw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module htw_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [htw_pkg::TO_W-1:0]  x,
  input  logic [htw_pkg::TP_W-1:0]  d,
  output logic                      busy,
  output logic                      valid,
  output logic [htw_pkg::TO_W-1:0]  q,
  output logic [htw_pkg::TP_W-1:0]  r
);

  localparam int STEP_W = $clog2(htw_pkg::TO_W);

  logic [STEP_W-1:0]          step;
  logic [htw_pkg::TP_W-1:0]   dv;
  logic [htw_pkg::TP_W:0]     rem_sh;
  logic                       ge;
  logic [htw_pkg::TP_W-1:0]   rem_next;

  assign rem_sh   = {r, q[htw_pkg::TO_W-1]};
  assign ge       = rem_sh >= {1'b0, dv};
  assign rem_next = ge ? htw_pkg::TP_W'(rem_sh - {1'b0, dv}) : rem_sh[htw_pkg::TP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      valid <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      valid <= 1'b0;
      step  <= '0;
      r     <= '0;
      q     <= x;
      dv    <= d;
    end else if (busy) begin
      r    <= rem_next;
      q    <= {q[htw_pkg::TO_W-2:0], ge};
      step <= step + 1'b1;
      if (step == STEP_W'(htw_pkg::TO_W - 1)) begin
        busy  <= 1'b0;
        valid <= 1'b1;
      end
    end
  end

endmodule

### sv/htw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_dp
// Timer table, bucket heads, wheel positions, divider and result staging.
// ----------------------------------------------------------------------------
module htw_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  htw_pkg::cmd_t              cmd,
  output htw_pkg::sts_t              sts,
  input  logic [1:0]                 op,
  input  logic [htw_pkg::ID_W-1:0]   timer_id,
  input  logic [htw_pkg::TO_W-1:0]   timeout,
  input  logic [htw_pkg::REP_W-1:0]  repeat_count,
  input  logic                       cfg_wr_en,
  input  logic [htw_pkg::TP_W-1:0]   cfg_wr_data,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [1:0]                 event_res,
  output logic [htw_pkg::ID_W-1:0]   event_timer,
  output logic                       last
);

  // timer table
  logic [htw_pkg::TO_W-1:0]   tmo_mem [htw_pkg::TIMERS];
  logic [htw_pkg::REP_W-1:0]  rep_mem [htw_pkg::TIMERS];
  logic [htw_pkg::PTR_W-1:0]  nxt_mem [htw_pkg::TIMERS];
  logic [htw_pkg::TO_W-1:0]   tmo_rd;
  logic [htw_pkg::REP_W-1:0]  rep_rd;
  logic [htw_pkg::PTR_W-1:0]  nxt_rd;
  logic [htw_pkg::TIMERS-1:0] active;
  logic [htw_pkg::TIMERS-1:0] linked;

  // bucket heads
  logic [htw_pkg::ID_W-1:0]   head_mem [htw_pkg::HEADS];
  logic [htw_pkg::HEADS-1:0]  head_v;
  logic [htw_pkg::ID_W-1:0]   head_rd;
  logic                       head_vrd;
  logic [htw_pkg::HEAD_W-1:0] hidx;
  logic [htw_pkg::HEAD_W-1:0] haddr;

  // wheel
  logic [htw_pkg::SLOT_W-1:0] pos [htw_pkg::LEVELS];
  logic [htw_pkg::LEVELS-1:0] in_use;
  logic [htw_pkg::LEVELS-1:0] turn;
  logic [htw_pkg::LVL_W-1:0]  turn_top;

  // working item
  logic [htw_pkg::TP_W-1:0]   tp;
  logic [htw_pkg::TP_W-1:0]   eff_tp;
  logic [1:0]                 i_op;
  logic [htw_pkg::REP_W-1:0]  i_rep;
  logic [htw_pkg::ID_W-1:0]   cur;
  logic [htw_pkg::TO_W-1:0]   cur_t;
  logic [htw_pkg::REP_W-1:0]  cur_rep;
  logic [htw_pkg::PTR_W-1:0]  nxt;
  logic [htw_pkg::LVL_W-1:0]  dl;
  logic [htw_pkg::LVL_W-1:0]  lk_lvl;
  htw_pkg::fit_t              fit;

  // divider
  logic                       div_busy;
  logic                       div_valid;
  logic [htw_pkg::TO_W-1:0]   div_x;
  logic [htw_pkg::TO_W-1:0]   div_q;
  logic [htw_pkg::TP_W-1:0]   div_r;
  logic [htw_pkg::SLOT_W-1:0] step_q;
  logic [htw_pkg::LVL_W-1:0]  dl_m1;

  // result staging
  logic                       pend_v;
  htw_pkg::ev_t               pend_code;
  logic [htw_pkg::ID_W-1:0]   pend_id;
  logic [htw_pkg::CNT_W-1:0]  cnt;
  logic                       out_free;
  logic                       full;

  assign eff_tp = (tp == '0) ? htw_pkg::TP_W'(1) : tp;
  assign fit    = htw_pkg::level_fit(cur_t, eff_tp);
  assign dl_m1  = dl - 1'b1;

  always_comb begin
    turn    = '0;
    turn[0] = 1'b1;
    for (int k = 1; k < htw_pkg::LEVELS; k++) begin
      turn[k] = turn[k-1] && (pos[k-1] == htw_pkg::SLOT_W'(htw_pkg::SLOTS - 1)) && in_use[k];
    end
    turn_top = '0;
    for (int k = 0; k < htw_pkg::LEVELS; k++) begin
      if (turn[k]) turn_top = htw_pkg::LVL_W'(k);
    end
  end

  always_comb begin
    case (cmd.div_src)
      htw_pkg::DS_INSERT: div_x = cur_t >> (htw_pkg::SLOT_W * fit.lvl);
      htw_pkg::DS_MOD:    div_x = cur_t >> (htw_pkg::SLOT_W * dl);
      default: begin
        div_x = htw_pkg::TO_W'({div_r, htw_pkg::SLOT_W'(cur_t >> (htw_pkg::SLOT_W * dl_m1))});
      end
    endcase
  end

  // bucket step, at least one tick
  assign step_q = (div_q == '0) ? htw_pkg::SLOT_W'(1) : div_q[htw_pkg::SLOT_W-1:0];

  always_comb begin
    if (cmd.lk_rd) haddr = {lk_lvl, htw_pkg::SLOT_W'(pos[lk_lvl] + step_q)};
    else           haddr = {dl, pos[dl]};
  end

  htw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .x     (div_x),
    .d     (eff_tp),
    .busy  (div_busy),
    .valid (div_valid),
    .q     (div_q),
    .r     (div_r)
  );

  // memories
  always_ff @(posedge clk) begin
    if (cmd.nd_rd) begin
      tmo_rd <= tmo_mem[cur];
      rep_rd <= rep_mem[cur];
      nxt_rd <= nxt_mem[cur];
    end
    if (cmd.add_do) tmo_mem[cur] <= cur_t;
    if (cmd.add_do) begin
      rep_mem[cur] <= (i_rep == '0) ? htw_pkg::REP_W'(1) : i_rep;
    end else if (cmd.rep_wr && (cur_rep != htw_pkg::REPEAT_FOREVER)) begin
      rep_mem[cur] <= cur_rep - 1'b1;
    end
    if (cmd.lk_wr) begin
      nxt_mem[cur]   <= head_vrd ? {1'b0, head_rd} : htw_pkg::NULL_PTR;
      head_mem[hidx] <= cur;
    end
    if (cmd.dr_rd || cmd.lk_rd) begin
      head_rd  <= head_mem[haddr];
      head_vrd <= head_v[haddr];
      hidx     <= haddr;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tp     <= htw_pkg::TP_W'(1);
      active <= '0;
      linked <= '0;
      head_v <= '0;
      in_use <= htw_pkg::LEVELS'(1);
      for (int k = 0; k < htw_pkg::LEVELS; k++) pos[k] <= '0;
    end else begin
      if (cfg_wr_en) tp <= cfg_wr_data;
      if (cmd.accept && (op == htw_pkg::OP_CANCEL)) active[timer_id] <= 1'b0;
      if (cmd.add_do) active[cur] <= 1'b1;
      if (cmd.tick_do) begin
        for (int k = 0; k < htw_pkg::LEVELS; k++) begin
          if (turn[k]) pos[k] <= pos[k] + 1'b1;
        end
      end
      if (cmd.div_start && (cmd.div_src == htw_pkg::DS_INSERT)) begin
        for (int k = 0; k < htw_pkg::LEVELS; k++) begin
          if (htw_pkg::LVL_W'(k) <= fit.lvl) in_use[k] <= 1'b1;
        end
      end
      if (cmd.dr_take) head_v[hidx] <= 1'b0;
      if (cmd.nd_take) linked[cur] <= 1'b0;
      if (cmd.lk_wr) begin
        head_v[hidx] <= 1'b1;
        linked[cur]  <= 1'b1;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      i_op  <= op;
      i_rep <= repeat_count;
      cur   <= timer_id;
      cur_t <= timeout;
    end
    if (cmd.tick_do) dl <= turn_top;
    if (cmd.dl_dec) dl <= dl_m1;
    if (cmd.dr_take) cur <= head_rd;
    if (cmd.nxt_adv) cur <= nxt[htw_pkg::ID_W-1:0];
    if (cmd.nd_take) begin
      nxt     <= nxt_rd;
      cur_t   <= tmo_rd;
      cur_rep <= rep_rd;
    end
    if (cmd.div_start && (cmd.div_src == htw_pkg::DS_INSERT)) lk_lvl <= fit.lvl;
    if (cmd.div_start && (cmd.div_src == htw_pkg::DS_CASC)) lk_lvl <= dl_m1;
  end

  // result staging: one result is held back so that last can be set
  assign out_free = !out_valid || !out_stall;
  assign full     = cnt >= htw_pkg::CNT_W'(htw_pkg::RES_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
      cnt       <= '0;
    end else begin
      if (pend_v && ((cmd.emit && !full) || cmd.flush)) begin
        out_valid   <= 1'b1;
        event_res   <= pend_code;
        event_timer <= pend_id;
        last        <= cmd.flush;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.accept) cnt <= '0;
      if (cmd.emit && !full) begin
        pend_v    <= 1'b1;
        pend_code <= cmd.emit_code;
        pend_id   <= cur;
        cnt       <= cnt + 1'b1;
      end
      if (cmd.flush && pend_v) pend_v <= 1'b0;
    end
  end

  always_comb begin
    sts.linked_cur = linked[cur];
    sts.active_cur = active[cur];
    sts.fit_ok     = fit.ok;
    sts.head_null  = !head_vrd;
    sts.nxt_null   = nxt[htw_pkg::PTR_W-1];
    sts.dl_zero    = (dl == '0);
    sts.again      = (cur_rep == htw_pkg::REPEAT_FOREVER)
                     || ((cur_rep != htw_pkg::REP_W'(1)) && (cur_rep != '0));
    sts.div_busy   = div_busy;
    sts.div_valid  = div_valid;
    sts.emit_ok    = full || !pend_v || out_free;
    sts.flush_ok   = !pend_v || out_free;
    sts.is_tick    = (i_op == htw_pkg::OP_TICK);
  end

endmodule

### sv/htw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_ctrl
// Sequencer for add, cancel and tick transactions.
// ----------------------------------------------------------------------------
module htw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    in_op,
  input  htw_pkg::sts_t sts,
  output htw_pkg::cmd_t cmd,
  output logic          in_stall
);

  htw_pkg::state_t state;
  htw_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= htw_pkg::S_IDLE;
    else     state <= state_next;
  end

  assign in_stall = (state != htw_pkg::S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      htw_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (in_op)
            htw_pkg::OP_ADD:  state_next = htw_pkg::S_ADD;
            htw_pkg::OP_TICK: state_next = htw_pkg::S_TICK;
            default:          state_next = htw_pkg::S_FIN;
          endcase
        end
      end
      htw_pkg::S_ADD: begin
        if (sts.linked_cur || !sts.fit_ok) begin
          state_next = htw_pkg::S_FAIL;
        end else begin
          cmd.add_do    = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_src   = htw_pkg::DS_INSERT;
          state_next    = htw_pkg::S_DIV_Q;
        end
      end
      htw_pkg::S_TICK: begin
        cmd.tick_do = 1'b1;
        state_next  = htw_pkg::S_DR_RD;
      end
      htw_pkg::S_DR_RD: begin
        cmd.dr_rd  = 1'b1;
        state_next = htw_pkg::S_DR_HEAD;
      end
      htw_pkg::S_DR_HEAD: begin
        if (!sts.head_null) begin
          cmd.dr_take = 1'b1;
          state_next  = htw_pkg::S_ND_RD;
        end else if (sts.dl_zero) begin
          state_next = htw_pkg::S_FIN;
        end else begin
          cmd.dl_dec = 1'b1;
          state_next = htw_pkg::S_DR_RD;
        end
      end
      htw_pkg::S_ND_RD: begin
        cmd.nd_rd  = 1'b1;
        state_next = htw_pkg::S_ND_EVAL;
      end
      htw_pkg::S_ND_EVAL: begin
        cmd.nd_take = 1'b1;
        if (!sts.active_cur)   state_next = htw_pkg::S_RM;
        else if (!sts.dl_zero) state_next = htw_pkg::S_CASC;
        else                   state_next = htw_pkg::S_EXP;
      end
      htw_pkg::S_CASC: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = htw_pkg::DS_MOD;
        state_next    = htw_pkg::S_DIV_M;
      end
      htw_pkg::S_DIV_M: begin
        if (sts.div_valid) begin
          cmd.div_start = 1'b1;
          cmd.div_src   = htw_pkg::DS_CASC;
          state_next    = htw_pkg::S_DIV_Q;
        end
      end
      htw_pkg::S_DIV_Q: begin
        if (sts.div_valid) state_next = htw_pkg::S_LK_RD;
      end
      htw_pkg::S_LK_RD: begin
        cmd.lk_rd  = 1'b1;
        state_next = htw_pkg::S_LK_WR;
      end
      htw_pkg::S_LK_WR: begin
        cmd.lk_wr  = 1'b1;
        state_next = sts.is_tick ? htw_pkg::S_NEXT : htw_pkg::S_FIN;
      end
      htw_pkg::S_EXP: begin
        if (sts.emit_ok) begin
          cmd.emit      = 1'b1;
          cmd.emit_code = htw_pkg::EV_EXPIRED;
          state_next    = htw_pkg::S_REP;
        end
      end
      htw_pkg::S_REP: begin
        cmd.rep_wr = 1'b1;
        if (sts.again && sts.fit_ok) begin
          cmd.div_start = 1'b1;
          cmd.div_src   = htw_pkg::DS_INSERT;
          state_next    = htw_pkg::S_DIV_Q;
        end else begin
          state_next = htw_pkg::S_RM;
        end
      end
      htw_pkg::S_RM: begin
        if (sts.emit_ok) begin
          cmd.emit      = 1'b1;
          cmd.emit_code = htw_pkg::EV_REMOVED;
          state_next    = htw_pkg::S_NEXT;
        end
      end
      htw_pkg::S_FAIL: begin
        if (sts.emit_ok) begin
          cmd.emit      = 1'b1;
          cmd.emit_code = htw_pkg::EV_ADD_FAILED;
          state_next    = htw_pkg::S_FIN;
        end
      end
      htw_pkg::S_NEXT: begin
        if (!sts.nxt_null) begin
          cmd.nxt_adv = 1'b1;
          state_next  = htw_pkg::S_ND_RD;
        end else if (sts.dl_zero) begin
          state_next = htw_pkg::S_FIN;
        end else begin
          cmd.dl_dec = 1'b1;
          state_next = htw_pkg::S_DR_RD;
        end
      end
      htw_pkg::S_FIN: begin
        if (sts.flush_ok) begin
          cmd.flush  = 1'b1;
          state_next = htw_pkg::S_IDLE;
        end
      end
      default: state_next = htw_pkg::S_IDLE;
    endcase
  end

endmodule

### sv/hierarchical_timer_wheel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel
// Three-level timing wheel over a 64-slot timer table with expiry events.
// ----------------------------------------------------------------------------
//
//  channel  handshake             payload
//  -------  --------------------  ------------------------------------------
//  in       in_valid / in_stall   op, timer_id, timeout, repeat_count
//  out      out_valid / out_stall event_res, event_timer, last
//  cfg      cfg_wr_en             cfg_wr_data (tick_period)
//
//  One transaction is worked at a time. An add waits on the 24-step
//  restoring divider that finds the bucket. A tick drains buckets from the
//  highest level that turned down to level 0; each timer drained is
//  removed, expires for good, expires and is reinserted (one pass through
//  the divider) or cascades down a level (two passes through the divider).
//  Reset (rst, synchronous) empties all buckets and zeroes the wheel; it
//  takes effect with no clearing pass.
//  A stalled output holds the sequencer only when a further result must be
//  issued; one result waits in the output register, one more in staging.
//
module hierarchical_timer_wheel (
  input  logic                       clk,
  input  logic                       rst,
  // item input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 op,
  input  logic [htw_pkg::ID_W-1:0]   timer_id,
  input  logic [htw_pkg::TO_W-1:0]   timeout,
  input  logic [htw_pkg::REP_W-1:0]  repeat_count,
  // tick_period register
  input  logic                       cfg_wr_en,
  input  logic [htw_pkg::TP_W-1:0]   cfg_wr_data,
  // event output
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 event_res,
  output logic [htw_pkg::ID_W-1:0]   event_timer,
  output logic                       last
);

  htw_pkg::cmd_t cmd;
  htw_pkg::sts_t sts;

  // sequencer: walks buckets and timer lists, drives the datapath
  htw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_op    (op),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // timer table, bucket heads, wheel positions, divider, result staging
  htw_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .op           (op),
    .timer_id     (timer_id),
    .timeout      (timeout),
    .repeat_count (repeat_count),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .event_res    (event_res),
    .event_timer  (event_timer),
    .last         (last)
  );

  // an accepted transaction always has the sequencer busy in the cycle after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("sequencer idle right after accepting a transaction");

  // a divide request must start the divider
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> sts.div_busy)
    else $error("divider not running after start");

  // results are only issued when staging has room or the result limit is reached
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.emit_ok)
    else $error("result issued without room");

endmodule

### dv/htw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htw_checker
// Watches the item, event and tick_period channels of the timer wheel. It
// keeps its own copy of the wheel, works out the events that each item
// causes and matches every event transaction against the oldest one due.
// ----------------------------------------------------------------------------
module htw_checker
  import htw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        op,
  input  logic [ID_W-1:0]   timer_id,
  input  logic [TO_W-1:0]   timeout,
  input  logic [REP_W-1:0]  repeat_count,
  input  logic              cfg_wr_en,
  input  logic [TP_W-1:0]   cfg_wr_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        event_res,
  input  logic [ID_W-1:0]   event_timer,
  input  logic              last,
  output int                fails,
  output int                pending
);

  typedef struct {
    ev_t             res;
    logic [ID_W-1:0] id;
    logic            fin;
  } event_t;

  logic [TP_W-1:0]  period;
  logic [TO_W-1:0]  tmr_to   [TIMERS];
  logic [REP_W-1:0] tmr_rep  [TIMERS];
  bit               tmr_act  [TIMERS];
  bit               tmr_lnk  [TIMERS];
  int               tmr_nxt  [TIMERS];
  int               head     [HEADS];
  int               wheel_pos[LEVELS];
  bit               lvl_on   [LEVELS];

  event_t item_events[$];
  event_t due_events[$];
  int     item_cnt;

  assign pending = due_events.size();

  task automatic flag(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    fails++;
  endtask

  function automatic void note(input ev_t r, input int s);
    event_t e;
    if (item_cnt < RES_MAX) begin
      e.res = r;
      e.id  = s[ID_W-1:0];
      e.fin = 1'b0;
      item_events.push_back(e);
    end
    item_cnt++;
  endfunction

  function automatic longint unsigned tick_len(input int k);
    longint unsigned t;
    t = (period == 0) ? 1 : period;
    repeat (k) t = t * SLOTS;
    return t;
  endfunction

  function automatic void hook(input int k, input int s, input longint unsigned remain);
    longint unsigned tk, b;
    tk = tick_len(k);
    if (remain < tk) remain = tk;
    b = (wheel_pos[k] + remain / tk) % SLOTS;
    tmr_nxt[s] = head[k*SLOTS + int'(b)];
    head[k*SLOTS + int'(b)] = s;
    tmr_lnk[s] = 1;
  endfunction

  function automatic bit place(input int s);
    for (int k = 0; k < LEVELS; k++)
      if (longint'(tmr_to[s]) < tick_len(k) * SLOTS) begin
        for (int j = 0; j <= k; j++) lvl_on[j] = 1;
        hook(k, s, tmr_to[s]);
        return 1;
      end
    return 0;
  endfunction

  // newest first; upper levels move timers one level down
  function automatic void sweep(input int k);
    int cur, nxt, idx;
    bit again;
    idx = k*SLOTS + wheel_pos[k];
    cur = head[idx];
    head[idx] = TIMERS;
    while (cur < TIMERS) begin
      nxt = tmr_nxt[cur];
      tmr_nxt[cur] = TIMERS;
      tmr_lnk[cur] = 0;
      if (!tmr_act[cur]) note(EV_REMOVED, cur);
      else if (k > 0) hook(k-1, cur, tmr_to[cur] % tick_len(k));
      else begin
        note(EV_EXPIRED, cur);
        if (tmr_rep[cur] == REPEAT_FOREVER) again = 1;
        else begin
          tmr_rep[cur] = tmr_rep[cur] - 1'b1;
          again = tmr_rep[cur] != 0 && tmr_rep[cur] != REPEAT_FOREVER;
        end
        if (!again || !place(cur)) note(EV_REMOVED, cur);
      end
      cur = nxt;
    end
  endfunction

  function automatic void advance(input int k);
    wheel_pos[k]++;
    if (wheel_pos[k] >= SLOTS) begin
      wheel_pos[k] = 0;
      if (k + 1 < LEVELS && lvl_on[k+1]) advance(k + 1);
    end
    sweep(k);
  endfunction

  function automatic void predict(input logic [1:0] o, input int id,
                                  input logic [TO_W-1:0] to, input logic [REP_W-1:0] rep);
    logic [TO_W-1:0] old_to;
    item_events.delete();
    item_cnt = 0;
    case (o)
      OP_ADD: begin
        if (tmr_lnk[id]) note(EV_ADD_FAILED, id);
        else begin
          old_to = tmr_to[id];
          tmr_to[id] = to;
          if (place(id)) begin
            tmr_rep[id] = (rep == 0) ? 1 : rep;
            tmr_act[id] = 1;
          end else begin
            tmr_to[id] = old_to;
            note(EV_ADD_FAILED, id);
          end
        end
      end
      OP_CANCEL: tmr_act[id] = 0;
      OP_TICK:   advance(0);
      default: ;
    endcase
    if (item_events.size() > 0) item_events[item_events.size()-1].fin = 1'b1;
    foreach (item_events[i]) due_events.push_back(item_events[i]);
  endfunction

  initial fails = 0;

  always @(posedge clk) begin
    event_t e;
    if (rst) begin
      period = 1;
      due_events.delete();
      for (int i = 0; i < TIMERS; i++) begin
        tmr_act[i] = 0;
        tmr_lnk[i] = 0;
        tmr_nxt[i] = TIMERS;
      end
      for (int i = 0; i < HEADS; i++) head[i] = TIMERS;
      for (int k = 0; k < LEVELS; k++) begin
        wheel_pos[k] = 0;
        lvl_on[k] = (k == 0);
      end
    end else begin
      if (cfg_wr_en) period = cfg_wr_data;
      if (in_valid && !in_stall) predict(op, int'(timer_id), timeout, repeat_count);
      if (out_valid && !out_stall) begin
        if (due_events.size() == 0)
          flag($sformatf("unexpected event res=%0d timer=%0d", event_res, event_timer));
        else begin
          e = due_events.pop_front();
          if (event_res !== e.res)
            flag($sformatf("event_res %0d, want %0d", event_res, e.res));
          if (event_timer !== e.id)
            flag($sformatf("event_timer %0d, want %0d", event_timer, e.id));
          if (last !== e.fin)
            flag($sformatf("last %0d, want %0d (timer %0d)", last, e.fin, e.id));
        end
      end
    end
  end

endmodule

### dv/tb_hierarchical_timer_wheel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hierarchical_timer_wheel
// Drives add, cancel and tick transactions into the timer wheel across four
// phases with different tick periods and gap/stall patterns; the checker
// predicts every event and the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_hierarchical_timer_wheel;
  import htw_pkg::*;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        op = OP_TICK;
  logic [ID_W-1:0]   timer_id = '0;
  logic [TO_W-1:0]   timeout = '0;
  logic [REP_W-1:0]  repeat_count = '0;
  logic              cfg_wr_en = 1'b0;
  logic [TP_W-1:0]   cfg_wr_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        event_res;
  logic [ID_W-1:0]   event_timer;
  logic              last;

  int fails;
  int pending;
  int tx_pct = 0;   // chance of a sender gap before a transaction
  int rx_pct = 0;   // chance of stalling the event channel per cycle
  logic [TP_W-1:0] period;

  always #10 clk = ~clk;

  hierarchical_timer_wheel uut (.*);

  htw_checker chk (.*);

  // receiver stall, redrawn each cycle
  always @(posedge clk)
    out_stall <= (rx_pct > 0) && ($urandom_range(99) < rx_pct);

  // one transaction on the item channel; valid stays high into the next one
  // unless a gap is drawn
  task automatic send(input logic [1:0] o, input int id,
                      input longint unsigned to, input int rep);
    if (tx_pct > 0 && $urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= o;
    timer_id     <= id[ID_W-1:0];
    timeout      <= (to > 24'hFFFFFF) ? 24'hFFFFFF : to[TO_W-1:0];
    repeat_count <= rep[REP_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // tick_period only changes once the wheel is idle and every event is out
  task automatic set_period(input logic [TP_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || in_stall) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    period = v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // adds are spread over the level spans of the current period, with a
  // share of full-range timeouts that mostly fail
  task automatic random_item();
    int r;
    longint unsigned to, tk;
    int rep;
    r  = $urandom_range(99);
    tk = period;
    case ($urandom_range(4))
      0: to = $urandom_range(0, 5);
      1: to = $urandom % (tk * SLOTS * 2 + 1);
      2: to = $urandom % (tk * SLOTS * SLOTS * 2 + 1);
      3: to = $urandom % (tk * SLOTS * SLOTS * SLOTS + 1);
      default: to = $urandom & 32'hFFFFFF;
    endcase
    case ($urandom_range(4))
      0: rep = 1;
      1: rep = $urandom_range(0, 4);
      2: rep = 65535;
      3: rep = 65534;
      default: rep = $urandom & 16'hFFFF;
    endcase
    if (r < 35)      send(OP_ADD, $urandom_range(0, TIMERS - 1), to, rep);
    else if (r < 45) send(OP_CANCEL, $urandom_range(0, TIMERS - 1), $urandom, $urandom);
    else if (r < 95) send(OP_TICK, $urandom_range(0, TIMERS - 1), $urandom, $urandom);
    else             send(2'd3, $urandom_range(0, TIMERS - 1), $urandom, $urandom);
  endtask

  initial begin
    logic [TP_W-1:0] periods [4];
    periods[0] = 16'd1;
    periods[1] = 16'hFFFF;
    periods[2] = 16'($urandom_range(2, 300));
    periods[3] = 16'd7;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 57; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 57; end
        default: begin tx_pct = 30; rx_pct = 30; end
      endcase
      set_period(periods[ph]);

      if (ph == 0) begin
        // tick_period 1: level spans are 64, 4096 and 262144 ms
        send(OP_ADD, 0, 0, 1);             // zero timeout, one tick ahead
        send(OP_ADD, 1, 63, 0);            // top of level 0, zero repeat
        send(OP_ADD, 2, 64, 2);            // first timeout on level 1
        send(OP_ADD, 3, 262143, 65535);    // top of level 2, forever
        send(OP_ADD, 4, 262144, 1);        // beyond top level
        send(OP_ADD, 5, 24'hFFFFFF, 16'hFFFF);
        send(OP_ADD, 0, 5, 1);             // slot still linked
        send(OP_CANCEL, 1, 0, 0);
        send(OP_CANCEL, 5, 0, 0);          // slot never added
        send(2'd3, 6, 1, 1);               // unused op
        send(OP_ADD, 6, 1, 65534);
        send(OP_ADD, 7, 2, 3);
        send(OP_ADD, 63, 4095, 2);
        send(OP_ADD, 1, 10, 1);            // cancelled but not yet drained
        for (int i = 0; i < 4; i++) send(OP_TICK, 0, 0, 0);
        send(OP_CANCEL, 6, 0, 0);
        for (int i = 0; i < 4; i++) send(OP_TICK, 0, 0, 0);
      end

      for (int i = 0; i < 22; i++) random_item();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || in_stall) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fails == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // overall watchdog
  initial begin
    #200_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
